// File: hdl/twil_pkg.sv
// Shared types and constants of the trie insert and lookup engine.
package twil_pkg;

    localparam int MAX_NODES_DEF    = 4096;
    localparam int LETTER_COUNT_DEF = 27;

    localparam int FUNC_W   = 2;
    localparam int LETTER_W = 5;
    localparam int STATUS_W = 2;
    localparam int LETX_W   = 7;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_INS_LETTER  = 2'd0,
        FUNC_LOOK_LETTER = 2'd1,
        FUNC_INS_FINISH  = 2'd2,
        FUNC_LOOK_FINISH = 2'd3
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_ABSENT = 2'd1,
        ST_FULL   = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } t_state;

endpackage

// File: hdl/twil_if.sv
// Valid/ready channel interfaces for letter items and word results.
interface twil_in_if
    import twil_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic [LETTER_W-1:0] letter;

    modport source (output valid, output func, output letter, input ready);
    modport sink   (input valid, input func, input letter, output ready);
endinterface

interface twil_out_if
    import twil_pkg::*;
#(
    parameter int NODE_W = $clog2(MAX_NODES_DEF),
    parameter int CNT_W  = $clog2(MAX_NODES_DEF + 1)
) ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [NODE_W-1:0]   end_node;
    logic [CNT_W-1:0]    nodes_used;

    modport source (output valid, output status, output end_node, output nodes_used,
                    input ready);
    modport sink   (input valid, input status, input end_node, input nodes_used,
                    output ready);
endinterface

// File: hdl/twil_row_ram.sv
// Single-port-write, single-port-read node row memory with registered read data.
module twil_row_ram
    import twil_pkg::*;
#(
    parameter int DEPTH = MAX_NODES_DEF,
    parameter int AW    = $clog2(MAX_NODES_DEF),
    parameter int DW    = LETTER_COUNT_DEF * $clog2(MAX_NODES_DEF) + 1
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hdl/twil_ctrl.sv
// Sequencer of the trie engine: clearing pass, row read-modify-write, result register.
module twil_ctrl
    import twil_pkg::*;
#(
    parameter int MAX_NODES    = MAX_NODES_DEF,
    parameter int LETTER_COUNT = LETTER_COUNT_DEF,
    parameter int NW           = $clog2(MAX_NODES),
    parameter int CW           = $clog2(MAX_NODES + 1),
    parameter int DW           = LETTER_COUNT * NW + 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    twil_in_if.sink       i_in,
    twil_out_if.source    o_out,
    output logic          o_wr_en,
    output logic [NW-1:0] o_wr_addr,
    output logic [DW-1:0] o_wr_data,
    output logic          o_rd_en,
    output logic [NW-1:0] o_rd_addr,
    input  logic [DW-1:0] i_rd_data
);

    localparam int LW       = $clog2(LETTER_COUNT);
    localparam int PTR_BITS = LETTER_COUNT * NW;

    t_state                          r_state, n_state;
    logic [NW-1:0]                   r_clr_addr, n_clr_addr;
    t_func                           r_func;
    logic [LETTER_W-1:0]             r_letter;
    logic [NW-1:0]                   r_cursor, n_cursor;
    logic                            r_failed, n_failed;
    logic                            r_pool, n_pool;
    logic [CW-1:0]                   r_count, n_count;
    logic                            r_out_valid, n_out_valid;
    t_status                         r_out_status;
    logic [NW-1:0]                   r_out_end;
    logic [CW-1:0]                   r_out_used;

    logic                            w_in_xfer;
    logic                            w_exec_go;
    logic [LETTER_COUNT-1:0][NW-1:0] w_ptrs;
    logic                            w_mark;
    logic [LETX_W-1:0]               w_letx;
    logic                            w_letter_ok;
    logic [LW-1:0]                   w_idx;
    logic [NW-1:0]                   w_child;
    logic [NW-1:0]                   w_new;
    logic [LETTER_COUNT-1:0][NW-1:0] w_wr_ptrs;
    logic                            w_wr_mark;
    logic                            w_load;
    t_status                         w_status;
    logic [NW-1:0]                   w_end;

    assign w_in_xfer   = i_in.valid && i_in.ready;
    assign w_exec_go   = (r_func == FUNC_INS_LETTER) || (r_func == FUNC_LOOK_LETTER)
                         || !r_out_valid || o_out.ready;
    assign w_ptrs      = i_rd_data[PTR_BITS-1:0];
    assign w_mark      = i_rd_data[DW-1];
    assign w_letx      = LETX_W'(r_letter);
    assign w_letter_ok = w_letx < LETX_W'(LETTER_COUNT);
    assign w_idx       = w_letx[LW-1:0];
    assign w_child     = w_ptrs[w_idx];
    assign w_new       = r_count[NW-1:0];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == NW'(MAX_NODES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_exec_go) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        i_in.ready = 1'b0;
        o_rd_en    = 1'b0;
        n_clr_addr = r_clr_addr;
        unique case (r_state)
            S_CLEAR: n_clr_addr = r_clr_addr + NW'(1);
            S_IDLE: begin
                i_in.ready = 1'b1;
                o_rd_en    = i_in.valid;
            end
            S_EXEC:  i_in.ready = 1'b0;
            default: i_in.ready = 1'b0;
        endcase
    end

    assign o_rd_addr = r_cursor;

    always_comb begin
        n_cursor  = r_cursor;
        n_failed  = r_failed;
        n_pool    = r_pool;
        n_count   = r_count;
        o_wr_en   = 1'b0;
        o_wr_addr = r_cursor;
        w_wr_ptrs = w_ptrs;
        w_wr_mark = w_mark;
        w_load    = 1'b0;
        w_status  = ST_OK;
        w_end     = '0;
        if (r_state == S_CLEAR) begin
            o_wr_en   = 1'b1;
            o_wr_addr = r_clr_addr;
            w_wr_ptrs = '0;
            w_wr_mark = 1'b0;
        end else if (r_state == S_EXEC && w_exec_go) begin
            case (r_func) inside
                FUNC_INS_LETTER, FUNC_LOOK_LETTER: begin
                    if (!r_failed) begin
                        if (!w_letter_ok) begin
                            n_failed = 1'b1;
                        end else if (w_child != '0) begin
                            n_cursor = w_child;
                        end else if (r_func == FUNC_LOOK_LETTER) begin
                            n_failed = 1'b1;
                        end else if (r_count >= CW'(MAX_NODES)) begin
                            n_pool   = 1'b1;
                            n_failed = 1'b1;
                        end else begin
                            n_count          = r_count + CW'(1);
                            o_wr_en          = 1'b1;
                            w_wr_ptrs[w_idx] = w_new;
                            n_cursor         = w_new;
                        end
                    end
                end
                default: begin
                    w_load   = 1'b1;
                    n_cursor = '0;
                    n_failed = 1'b0;
                    n_pool   = 1'b0;
                    if (r_pool) begin
                        w_status = ST_FULL;
                    end else if (r_failed) begin
                        w_status = ST_ABSENT;
                    end else if (r_func == FUNC_INS_FINISH) begin
                        o_wr_en   = 1'b1;
                        w_wr_mark = 1'b1;
                        w_end     = r_cursor;
                    end else if (w_mark) begin
                        w_end = r_cursor;
                    end else begin
                        w_status = ST_ABSENT;
                    end
                end
            endcase
        end
    end

    assign o_wr_data = {w_wr_mark, PTR_BITS'(w_wr_ptrs)};

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
        if (w_load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_cursor    <= '0;
            r_failed    <= 1'b0;
            r_pool      <= 1'b0;
            r_count     <= CW'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_cursor    <= n_cursor;
            r_failed    <= n_failed;
            r_pool      <= n_pool;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_func   <= t_func'(i_in.func);
            r_letter <= i_in.letter;
        end
        if (w_load) begin
            r_out_status <= w_status;
            r_out_end    <= w_end;
            r_out_used   <= r_count;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.status     = r_out_status;
    assign o_out.end_node   = r_out_end;
    assign o_out.nodes_used = r_out_used;

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (r_count != $past(r_count)) |-> r_count == $past(r_count) + CW'(1))
        else $error("Node count changed by other than one allocation.");

    a_cursor_allocated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CW'(r_cursor) < r_count)
        else $error("Cursor points at a node that was never allocated.");

    a_full_fails: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pool |-> r_failed)
        else $error("Pool exhaustion seen without failing the word.");

    a_result_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_EXEC)
            && ($past(r_func) == FUNC_INS_FINISH || $past(r_func) == FUNC_LOOK_FINISH))
        else $error("Result produced by something other than a finish item.");

endmodule

// File: hdl/trie_word_insert_lookup.sv
// Top level of the trie word insert and lookup engine.
//
// Words arrive on i_in one letter per transfer: func selects insert letter, lookup
// letter, finish insert or finish lookup, and letter gives the letter index.
// Letter items produce nothing; each finish item produces one transfer on o_out
// with the status, the node reached by the word and the number of nodes in use.
// Every item first reads the current node's row (all child pointers and the word
// end flag) from the node memory in S_IDLE, then updates the row and writes it back
// in S_EXEC where needed; a new input item is taken only once the last is through.
// A finish result is loaded into the output register in S_EXEC once that is free.
// The result sits in an output register; while it waits, letter items are still
// taken, and a following finish item holds until the register is freed.
// After reset a clearing pass writes every node row to zero, one row per cycle,
// over all MAX_NODES rows (4096 by default), with i_in.ready held low.
// The node pool is not reused: an insert that runs out of nodes reports pool full.
module trie_word_insert_lookup
    import twil_pkg::*;
#(
    parameter int MAX_NODES    = MAX_NODES_DEF,
    parameter int LETTER_COUNT = LETTER_COUNT_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    twil_in_if.sink    i_in,
    twil_out_if.source o_out
);

    localparam int NW = $clog2(MAX_NODES);
    localparam int CW = $clog2(MAX_NODES + 1);
    localparam int DW = LETTER_COUNT * NW + 1;

    logic          w_wr_en;
    logic [NW-1:0] w_wr_addr;
    logic [DW-1:0] w_wr_data;
    logic          w_rd_en;
    logic [NW-1:0] w_rd_addr;
    logic [DW-1:0] w_rd_data;

    twil_ctrl #(
        .MAX_NODES    (MAX_NODES),
        .LETTER_COUNT (LETTER_COUNT),
        .NW           (NW),
        .CW           (CW),
        .DW           (DW)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .o_out     (o_out),
        .o_wr_en   (w_wr_en),
        .o_wr_addr (w_wr_addr),
        .o_wr_data (w_wr_data),
        .o_rd_en   (w_rd_en),
        .o_rd_addr (w_rd_addr),
        .i_rd_data (w_rd_data)
    );

    twil_row_ram #(
        .DEPTH (MAX_NODES),
        .AW    (NW),
        .DW    (DW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

endmodule
